>>> rtl/whc_pkg.sv
// Package for the multiply-xor word hash core: constants, command type and
// the sizes shared by the front end, the command queue and the back end.
// No dependencies.
package whc_pkg;

  localparam int BYTE_W  = 8;
  localparam int HASH_W  = 32;
  localparam int ACC_W   = 64;
  localparam int HALF_W  = 32;
  localparam int BUF_W   = 56;
  localparam int COUNT_W = 8;

  localparam logic [ACC_W-1:0] HASH_INIT = 64'd2166136261;
  localparam logic [ACC_W-1:0] WORD_MULT = 64'hbf58476d1ce4e5b9;
  localparam logic [ACC_W-1:0] TAIL_MULT = 64'hd6e8feb86659fd93;

  // Default depth of the queue between front and back end
  localparam int QUEUE_DEPTH = 4;

  // Which multiplier constant a command applies after the XOR
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_WORD,
    MUL_TAIL
  } mult_sel_t;

  // One unit of work for the back end
  typedef struct packed {
    logic [ACC_W-1:0] word;  // value XORed into the accumulator
    mult_sel_t        mult;  // multiplier applied afterwards
    logic             fin;   // end of message: fold and emit the hash
  } cmd_t;

  // Queue status seen by the front and back end
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> rtl/whc_if.sv
// Channel interfaces of the multiply-xor word hash core: byte input and
// hash output, each with valid/ready. Depends on whc_pkg.
interface whc_in_if;
  import whc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              byte_valid;
  logic              last;

  modport source(output valid, data_byte, byte_valid, last, input ready);
  modport sink(input valid, data_byte, byte_valid, last, output ready);
endinterface

interface whc_out_if;
  import whc_pkg::*;

  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] hash_value;

  modport source(output valid, hash_value, input ready);
  modport sink(input valid, hash_value, output ready);
endinterface

>>> rtl/whc_front.sv
// Front end of the hash core: packs bytes into words, counts the message
// length and issues word, tail and end commands. Depends on whc_pkg, whc_if.
module whc_front (
  input  logic             clk,
  input  logic             rst_n,
  whc_in_if.sink           in_chan,
  input  whc_pkg::q_stat_t q_stat,
  output logic             push,
  output whc_pkg::cmd_t    push_cmd
);
  import whc_pkg::*;

  logic [BUF_W-1:0]   buf_r, buf_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;

  logic [2:0]         pos;
  logic               full_word;
  logic [BUF_W-1:0]   buf_ins;
  logic [BUF_W-1:0]   buf_after;
  logic [COUNT_W-1:0] cnt_after;
  logic               accept;

  assign in_chan.ready = !q_stat.full;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    pos       = cnt_r[2:0];
    full_word = in_chan.byte_valid && (pos == 3'd7);
    buf_ins   = buf_r | ({{(BUF_W-BYTE_W){1'b0}}, in_chan.data_byte} << {pos, 3'b000});
    if (full_word) begin
      buf_after = '0;
    end else if (in_chan.byte_valid) begin
      buf_after = buf_ins;
    end else begin
      buf_after = buf_r;
    end
    cnt_after = cnt_r + COUNT_W'(in_chan.byte_valid);

    // a tail and a full word never meet: a full word leaves the count on a word boundary
    priority if (in_chan.last && (cnt_after[2:0] != 3'd0)) begin
      push_cmd.word = {buf_after, cnt_after};
      push_cmd.mult = MUL_TAIL;
      push_cmd.fin  = 1'b1;
    end else if (full_word) begin
      push_cmd.word = {in_chan.data_byte, buf_r};
      push_cmd.mult = MUL_WORD;
      push_cmd.fin  = in_chan.last;
    end else begin
      push_cmd.word = '0;
      push_cmd.mult = MUL_NONE;
      push_cmd.fin  = 1'b1;
    end
    push = accept && (full_word || in_chan.last);

    // drop the partial word at end of message
    if (in_chan.last) begin
      buf_nxt = '0;
      cnt_nxt = '0;
    end else begin
      buf_nxt = buf_after;
      cnt_nxt = cnt_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r <= '0;
      cnt_r <= '0;
    end else if (accept) begin
      buf_r <= buf_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/whc_queue.sv
// Command queue between front and back end of the hash core: a small
// circular buffer of commands. Depends on whc_pkg.
module whc_queue #(
  parameter int DEPTH = whc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  whc_pkg::cmd_t     push_cmd,
  input  logic              pop,
  output whc_pkg::cmd_t     pop_cmd,
  output whc_pkg::q_stat_t  q_stat
);
  import whc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign pop_cmd      = mem[rd_ptr_r];
  assign q_stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/whc_back.sv
// Back end of the hash core: XORs commands into the accumulator, multiplies
// modulo 2^64 on one shared 32x32 multiplier, folds and holds the result.
// Depends on whc_pkg, whc_if.
module whc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  whc_pkg::cmd_t    pop_cmd,
  input  whc_pkg::q_stat_t q_stat,
  output logic             pop,
  whc_out_if.source        out_chan
);
  import whc_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_FIN
  } back_state_t;

  back_state_t        state_r;
  logic [1:0]         step_r;
  logic [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]   x_r;
  mult_sel_t          mult_r;
  logic               fin_r;
  logic [ACC_W-1:0]   prod_r;
  logic [HALF_W-1:0]  lo_r;
  logic [HALF_W-1:0]  hi_r;
  logic               out_valid_r;
  logic [HASH_W-1:0]  out_hash_r;

  logic [ACC_W-1:0]   mconst;
  logic [HALF_W-1:0]  mul_a;
  logic [HALF_W-1:0]  mul_b;
  logic [ACC_W-1:0]   mul_p;
  logic               slot_free;

  assign pop                 = (state_r == B_IDLE) && !q_stat.empty;
  assign slot_free           = !out_valid_r || out_chan.ready;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.hash_value = out_hash_r;

  // Low 64 bits of x * c: x_lo*c_lo, then the two cross terms into the high half
  always_comb begin
    mconst = (mult_r == MUL_TAIL) ? TAIL_MULT : WORD_MULT;
    unique case (step_r)
      2'd0: begin
        mul_a = x_r[HALF_W-1:0];
        mul_b = mconst[HALF_W-1:0];
      end
      2'd1: begin
        mul_a = x_r[ACC_W-1:HALF_W];
        mul_b = mconst[HALF_W-1:0];
      end
      default: begin
        mul_a = x_r[HALF_W-1:0];
        mul_b = mconst[ACC_W-1:HALF_W];
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      step_r      <= '0;
      acc_r       <= HASH_INIT;
      out_valid_r <= 1'b0;
    end else begin
      // load a new result when the back end finishes, else drop one that transfers
      if ((state_r == B_FIN) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (pop) begin
            x_r    <= acc_r ^ pop_cmd.word;
            mult_r <= pop_cmd.mult;
            fin_r  <= pop_cmd.fin;
            step_r <= '0;
            if (pop_cmd.mult != MUL_NONE) begin
              state_r <= B_MUL;
            end else if (pop_cmd.fin) begin
              state_r <= B_FIN;
            end
          end
        end
        B_MUL: begin
          step_r <= step_r + 2'd1;
          unique case (step_r)
            2'd0: begin
              prod_r <= mul_p;
            end
            2'd1: begin
              lo_r   <= prod_r[HALF_W-1:0];
              hi_r   <= prod_r[ACC_W-1:HALF_W];
              prod_r <= mul_p;
            end
            2'd2: begin
              hi_r   <= hi_r + prod_r[HALF_W-1:0];
              prod_r <= mul_p;
            end
            default: begin
              acc_r   <= {hi_r + prod_r[HALF_W-1:0], lo_r};
              state_r <= fin_r ? B_FIN : B_IDLE;
            end
          endcase
        end
        B_FIN: begin
          // hold until the output register is free, then restart the accumulator
          if (slot_free) begin
            out_hash_r  <= acc_r[HALF_W-1:0] ^ acc_r[ACC_W-1:HALF_W];
            acc_r       <= HASH_INIT;
            state_r     <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/word_multiply_xor_hash_core.sv
// Top level of the multiply-xor word hash core: front end, command queue and
// back end. Depends on whc_pkg, whc_if, whc_front, whc_queue, whc_back.
//
//   channel  | dir | handshake       | payload
//   ---------+-----+-----------------+----------------------------------------
//   in_chan  | in  | valid / ready   | data_byte[7:0], byte_valid, last
//   out_chan | out | valid / ready   | hash_value[31:0]
//
// One byte transfer per cycle is taken while the command queue has room.
// Every eighth byte becomes a word command, which the back end handles in a
// load and four steps of the shared 32x32 multiplier, so a long message
// streams at one byte per cycle while the queue has room. The end of a
// message takes the back end through B_FIN, after the four multiplier steps
// when a tail word is multiplied in; a run of very short messages is set by
// the back end, with the queue of QUEUE_DEPTH commands absorbing bursts.
// Reset is synchronous and active low: the accumulator returns to its seed,
// the queue empties and no result is held. A stalled result holds in the
// output register; the back end stops there and the queue then fills until
// the input stalls too.
module word_multiply_xor_hash_core #(
  parameter int QUEUE_DEPTH = whc_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  whc_in_if.sink     in_chan,
  whc_out_if.source  out_chan
);
  import whc_pkg::*;

  // front to queue
  logic    push;
  cmd_t    push_cmd;
  // queue to back
  logic    pop;
  cmd_t    pop_cmd;
  q_stat_t q_stat;

  // Pack bytes, count length, issue commands
  whc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decouple byte intake from the multiplier
  whc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  // Mix, multiply, fold and hold the result
  whc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

`ifndef SYNTHESIS
  // the front end never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("command pushed into full queue");

  // the back end never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("command popped from empty queue");

  // a push without a pop leaves the queue non-empty next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !q_stat.empty)
    else $error("pushed command lost");

  // queue status is never both full and empty
  a_stat_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");
`endif

endmodule
